// File: src/wps_pkg.sv
// Package for the waveform pixel shader: widths, register indexes, reset values and types.
`default_nettype none

package wps_pkg;

    // Default parameter values handed to the top level.
    localparam int ROW_BITS_DEF        = 12;
    localparam int LEVEL_FRAC_BITS_DEF = 14;

    // Fixed field widths.
    localparam int SAMPLE_W   = 16;
    localparam int CH_W       = 8;
    localparam int RGB_W      = 3 * CH_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RGB_W;

    // Quotient bits resolved by each divider stage.
    localparam int DIV_BITS_PER_STAGE = 4;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACKGROUND = 2'd0,
        CFG_FOREGROUND = 2'd1,
        CFG_HIGHLIGHT  = 2'd2,
        CFG_ROW_COUNT  = 2'd3
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam logic [RGB_W-1:0] BACKGROUND_RESET = 24'h000000;
    localparam logic [RGB_W-1:0] FOREGROUND_RESET = 24'hFFFFFF;
    localparam logic [RGB_W-1:0] HIGHLIGHT_RESET  = 24'h0000FF;
    localparam int               ROW_COUNT_RESET  = 64;

    // One colour channel and a packed colour, index 2 being red.
    typedef logic [CH_W-1:0] t_chan;
    typedef t_chan [2:0]     t_rgb;

    // Column span carried alongside the row division.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
    } t_span;

endpackage

`default_nettype wire

// File: src/wps_in_if.sv
// Stream interface carrying one pixel request: column span and row.
`default_nettype none

interface wps_in_if
    import wps_pkg::*;
#(
    parameter int ROW_BITS = ROW_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_low;
    logic signed [SAMPLE_W-1:0] sample_high;
    logic [ROW_BITS-1:0]        row;

    modport source (output valid, output sample_low, output sample_high, output row,
                    input ready);
    modport sink   (input valid, input sample_low, input sample_high, input row,
                    output ready);
endinterface

`default_nettype wire

// File: src/wps_out_if.sv
// Stream interface carrying one shaded pixel pair.
`default_nettype none

interface wps_out_if
    import wps_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [RGB_W-1:0] plain_pixel;
    logic [RGB_W-1:0] played_pixel;

    modport source (output valid, output plain_pixel, output played_pixel, input ready);
    modport sink   (input valid, input plain_pixel, input played_pixel, output ready);
endinterface

`default_nettype wire

// File: src/wps_divider.sv
// Pipelined restoring divider: rounded row position in units of half the strip height.
`default_nettype none

module wps_divider
    import wps_pkg::*;
#(
    parameter int ROW_BITS        = ROW_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
    localparam int DW             = ROW_BITS + 1,
    localparam int NW             = ROW_BITS + LEVEL_FRAC_BITS + 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [DW-1:0]       i_den,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [ROW_BITS-1:0] i_row,
    input  wire t_span               i_span,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [NW-1:0]            o_quot,
    output t_span                    o_span
);

    localparam int BPS  = DIV_BITS_PER_STAGE;
    localparam int NSTG = (NW + BPS - 1) / BPS;

    logic [NSTG:0]   r_vld;
    logic [NSTG+1:0] adv;
    logic [DW-1:0]   r_rem [0:NSTG];
    logic [NW-1:0]   r_num [0:NSTG];
    t_span           r_span [0:NSTG];
    logic [DW-1:0]   n_rem [1:NSTG];
    logic [NW-1:0]   n_num [1:NSTG];
    logic [NW-1:0]   n_num0;

    // A stage moves on when it is empty or its successor moves on.
    always_comb begin
        adv[NSTG+1] = i_ready;
        for (int s = NSTG; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_vld[NSTG];
    assign o_quot  = r_num[NSTG];
    assign o_span  = r_span[NSTG];

    // Numerator with half the divisor added for rounding to nearest.
    assign n_num0 = {1'b0, i_row, {(LEVEL_FRAC_BITS + 1){1'b0}}} + NW'(i_den[DW-1:1]);

    // Each stage resolves a few quotient bits, shifted into the numerator word.
    always_comb begin
        logic [DW-1:0] rem;
        logic [NW-1:0] num;
        logic [DW:0]   rt;
        for (int s = 1; s <= NSTG; s++) begin
            rem = r_rem[s-1];
            num = r_num[s-1];
            for (int j = 0; j < BPS; j++) begin
                if ((s - 1) * BPS + j < NW) begin
                    rt  = {rem, num[NW-1]};
                    num = {num[NW-2:0], 1'b0};
                    if (rt >= {1'b0, i_den}) begin
                        rt     = rt - {1'b0, i_den};
                        num[0] = 1'b1;
                    end
                    rem = rt[DW-1:0];
                end
            end
            n_rem[s] = rem;
            n_num[s] = num;
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s <= NSTG; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_rem[0]  <= '0;
            r_num[0]  <= n_num0;
            r_span[0] <= i_span;
        end
        for (int s = 1; s <= NSTG; s++) begin
            if (adv[s]) begin
                r_rem[s]  <= n_rem[s];
                r_num[s]  <= n_num[s];
                r_span[s] <= r_span[s-1];
            end
        end
    end

endmodule

`default_nettype wire

// File: src/wps_shade.sv
// Shading pipeline: level, edge distance, colour blend, clamp and highlight mix.
`default_nettype none

module wps_shade
    import wps_pkg::*;
#(
    parameter int ROW_BITS        = ROW_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
    localparam int NW             = ROW_BITS + LEVEL_FRAC_BITS + 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_rgb          i_bg,
    input  wire t_rgb          i_fg,
    input  wire t_rgb          i_hl,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [NW-1:0] i_quot,
    input  wire t_span         i_span,
    output logic               o_valid,
    input  wire logic          i_ready,
    output t_rgb               o_plain,
    output t_rgb               o_played
);

    localparam int F     = LEVEL_FRAC_BITS;
    localparam int LW    = NW + 1;
    localparam int CW    = ((LW > SAMPLE_W) ? LW : SAMPLE_W) + 1;
    localparam int FW    = SAMPLE_W + 3;
    localparam int PW    = FW + 1 + CH_W + 1;
    localparam int UW    = CH_W + F;
    localparam int TW    = (((UW + 1) > PW) ? (UW + 1) : PW) + 1;
    localparam int QW    = CH_W + F + 3;
    localparam int NSTG  = 5;

    localparam logic signed [CW-1:0] ONE_L = CW'(1) << F;
    localparam logic signed [TW-1:0] TMAX  = TW'((2 ** CH_W) - 1) << F;

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   adv;

    // Stage registers.
    logic [CW-1:0]          r_dist_lo, r_dist_hi;
    logic                   r_outside;
    logic [FW-1:0]          r_gain;
    logic signed [PW-1:0]   r_prod [0:2];
    logic [UW-1:0]          r_t [0:2];
    t_rgb                   r_plain, r_played;

    // Next values.
    logic [CW-1:0]          n_dist_lo, n_dist_hi;
    logic                   n_outside;
    logic [FW-1:0]          n_gain;
    logic signed [PW-1:0]   n_prod [0:2];
    logic [UW-1:0]          n_t [0:2];
    t_rgb                   n_plain, n_played;

    // A stage moves on when it is empty or its successor moves on.
    always_comb begin
        adv[NSTG] = i_ready;
        for (int s = NSTG - 1; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign o_ready  = adv[0];
    assign o_valid  = r_vld[NSTG-1];
    assign o_plain  = r_plain;
    assign o_played = r_played;

    // Level of the row and its distances to both span edges.
    always_comb begin
        logic signed [CW-1:0] lvl, d_lo, d_hi;
        lvl       = ONE_L - signed'(CW'(i_quot));
        d_lo      = lvl - CW'(i_span.lo);
        d_hi      = lvl - CW'(i_span.hi);
        n_outside = d_lo[CW-1] || (!d_hi[CW-1] && (d_hi != '0));
        n_dist_lo = d_lo[CW-1] ? CW'(-d_lo) : CW'(d_lo);
        n_dist_hi = d_hi[CW-1] ? CW'(-d_hi) : CW'(d_hi);
    end

    // Blend gain: seven times the nearer distance; inside the span it fits the sample width.
    always_comb begin
        logic [CW-1:0]       dmin;
        logic [SAMPLE_W-1:0] d16;
        dmin   = (r_dist_lo < r_dist_hi) ? r_dist_lo : r_dist_hi;
        d16    = dmin[SAMPLE_W-1:0];
        n_gain = r_outside ? '0 : ({1'b0, d16, 2'b00} + {2'b00, d16, 1'b0} + FW'(d16));
    end

    // Gain times the foreground minus background difference, per channel.
    always_comb begin
        logic signed [CH_W:0] diff;
        for (int c = 0; c < 3; c++) begin
            diff      = signed'({1'b0, i_fg[c]}) - signed'({1'b0, i_bg[c]});
            n_prod[c] = PW'(signed'({1'b0, r_gain}) * diff);
        end
    end

    // Add the background term and clamp to the channel range.
    always_comb begin
        logic signed [TW-1:0] t;
        for (int c = 0; c < 3; c++) begin
            t = signed'(TW'({i_bg[c], {F{1'b0}}})) + TW'(r_prod[c]);
            if (t[TW-1]) begin
                n_t[c] = '0;
            end else if (t > TMAX) begin
                n_t[c] = UW'(TMAX);
            end else begin
                n_t[c] = t[UW-1:0];
            end
        end
    end

    // Round to the plain channel and mix a quarter of the highlight for the played one.
    always_comb begin
        logic [UW-1:0] ps;
        logic [QW-1:0] qs;
        for (int c = 0; c < 3; c++) begin
            ps          = r_t[c] + (UW'(1) << (F - 1));
            qs          = (QW'(i_hl[c]) << F) + QW'(r_t[c]) + (QW'(r_t[c]) << 1)
                        + (QW'(1) << (F + 1));
            n_plain[c]  = ps[F +: CH_W];
            n_played[c] = qs[(F + 2) +: CH_W];
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_dist_lo <= n_dist_lo;
            r_dist_hi <= n_dist_hi;
            r_outside <= n_outside;
        end
        if (adv[1]) begin
            r_gain <= n_gain;
        end
        if (adv[2]) begin
            r_prod <= n_prod;
        end
        if (adv[3]) begin
            r_t <= n_t;
        end
        if (adv[4]) begin
            r_plain  <= n_plain;
            r_played <= n_played;
        end
    end

endmodule

`default_nettype wire

// File: src/waveform_pixel_shader.sv
// Top level of the waveform pixel shader: configuration registers and the two pipeline parts.
//
//  Channel  Direction  Transfer contents
//  i_px     in         sample_low, sample_high (Q2.14), row
//  o_px     out        plain_pixel, played_pixel (8-bit red, green, blue)
//  i_cfg_*  in         register index and data, written when i_cfg_we is high
//
// One pixel is taken in every cycle while the output is not stalled; each passes from input
// transfer to output through the input register, the row divider stages and the shading stages.
// The synchronous active-low reset empties the pipeline and loads the register reset values.
// A stalled output holds every stage that is full; empty stages still fill, so input is
// accepted until the whole pipeline is full.
`default_nettype none

module waveform_pixel_shader
    import wps_pkg::*;
#(
    parameter int ROW_BITS        = ROW_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    wps_in_if.sink                     i_px,
    wps_out_if.source                  o_px
);

    localparam int DW = ROW_BITS + 1;
    localparam int NW = ROW_BITS + LEVEL_FRAC_BITS + 2;

    t_rgb          r_bg, r_fg, r_hl;
    logic [DW-1:0] r_rows;
    logic [DW-1:0] den;
    t_span         in_span, div_span;
    logic          div_valid, div_ready;
    logic [NW-1:0] div_quot;
    t_rgb          plain, played;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg   <= BACKGROUND_RESET;
            r_fg   <= FOREGROUND_RESET;
            r_hl   <= HIGHLIGHT_RESET;
            r_rows <= DW'(ROW_COUNT_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BACKGROUND: r_bg   <= i_cfg_data;
                CFG_FOREGROUND: r_fg   <= i_cfg_data;
                CFG_HIGHLIGHT:  r_hl   <= i_cfg_data;
                CFG_ROW_COUNT:  r_rows <= i_cfg_data[DW-1:0];
                default:        r_bg   <= r_bg;
            endcase
        end
    end

    // Level step divisor: rows less one, with fewer than two rows taken as two.
    assign den = (r_rows < DW'(2)) ? DW'(1) : (r_rows - DW'(1));

    assign in_span.lo = i_px.sample_low;
    assign in_span.hi = i_px.sample_high;

    wps_divider #(
        .ROW_BITS        (ROW_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_den   (den),
        .i_valid (i_px.valid),
        .o_ready (i_px.ready),
        .i_row   (i_px.row),
        .i_span  (in_span),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_quot  (div_quot),
        .o_span  (div_span)
    );

    wps_shade #(
        .ROW_BITS        (ROW_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_shade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bg     (r_bg),
        .i_fg     (r_fg),
        .i_hl     (r_hl),
        .i_valid  (div_valid),
        .o_ready  (div_ready),
        .i_quot   (div_quot),
        .i_span   (div_span),
        .o_valid  (o_px.valid),
        .i_ready  (o_px.ready),
        .o_plain  (plain),
        .o_played (played)
    );

    assign o_px.plain_pixel  = plain;
    assign o_px.played_pixel = played;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the waveform pixel shader: directed table, then randomised settings.

module tb_top;
    import wps_pkg::*;

    localparam int ROW_BITS       = ROW_BITS_DEF;
    localparam int FRAC           = LEVEL_FRAC_BITS_DEF;
    localparam int LATENCY        =
        (ROW_BITS + FRAC + 2 + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE + 6;
    localparam int NUM_SETTINGS   = 8;
    localparam int ITEMS_PER_SET  = 250;
    localparam int MAX_REPORTS    = 10;
    localparam int NUM_DIRECTED   = 20;

    // Expected shader output for one pixel.
    typedef struct packed {
        logic [RGB_W-1:0] plain;
        logic [RGB_W-1:0] played;
    } t_pixel_pair;

    // One row of the directed table; a fixed row carries its expected pair.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic [ROW_BITS-1:0]        row;
        logic                       fixed;
        t_pixel_pair                want;
    } t_directed_row;

    // Reset colours: background 0, foreground white, highlight blue.
    localparam t_pixel_pair BG_PAIR   = {24'h000000, 24'h000040};
    localparam t_pixel_pair FULL_PAIR = {24'hFFFFFF, 24'hBFBFFF};
    localparam t_pixel_pair NO_PAIR   = '0;

    // Directed rows, all at the reset settings (64 rows, row 31 sits at level 260).
    localparam t_directed_row DIRECTED [NUM_DIRECTED] = '{
        '{16'sh8000,     16'sh7FFF,     12'd0,    1'b1, FULL_PAIR},
        '{16'sh8000,     16'sh7FFF,     12'd63,   1'b1, FULL_PAIR},
        '{16'sd0,        16'sd100,      12'd0,    1'b1, BG_PAIR},
        '{16'sd20000,    16'sh7FFF,     12'd63,   1'b1, BG_PAIR},
        '{16'sd16384,    16'sh7FFF,     12'd0,    1'b1, BG_PAIR},
        '{16'sh8000,     -16'sd16384,   12'd63,   1'b1, BG_PAIR},
        '{16'sh7FFF,     16'sh8000,     12'd31,   1'b1, BG_PAIR},
        '{16'sd1,        16'sd0,        12'd31,   1'b1, BG_PAIR},
        '{16'sh8000,     16'sh7FFF,     12'd4095, 1'b1, BG_PAIR},
        '{16'sh8000,     16'sh8000,     12'd0,    1'b1, BG_PAIR},
        '{16'sh7FFF,     16'sh7FFF,     12'd0,    1'b1, BG_PAIR},
        '{-16'sd16384,   16'sd16384,    12'd0,    1'b1, BG_PAIR},
        '{16'sh8000,     16'sd0,        12'd64,   1'b0, NO_PAIR},
        '{16'sd259,      16'sh7FFF,     12'd31,   1'b0, NO_PAIR},
        '{16'sd160,      16'sd460,      12'd31,   1'b0, NO_PAIR},
        '{16'sh8000,     16'sd2600,     12'd31,   1'b0, NO_PAIR},
        '{-16'sd1000,    16'sd1000,     12'd31,   1'b0, NO_PAIR},
        '{16'sh8000,     16'sh7FFF,     12'd1,    1'b0, NO_PAIR},
        '{16'sh8000,     16'sh7FFF,     12'd32,   1'b0, NO_PAIR},
        '{16'sh8000,     16'sh7FFF,     12'd62,   1'b0, NO_PAIR}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    wps_in_if #(.ROW_BITS(ROW_BITS)) px_in ();
    wps_out_if                       px_out ();

    // Our copy of the configuration registers.
    logic [RGB_W-1:0]  bg_colour  = BACKGROUND_RESET;
    logic [RGB_W-1:0]  fg_colour  = FOREGROUND_RESET;
    logic [RGB_W-1:0]  hl_colour  = HIGHLIGHT_RESET;
    logic [ROW_BITS:0] strip_rows = (ROW_BITS + 1)'(ROW_COUNT_RESET);

    t_pixel_pair pending_pixels [$];
    int          fail_count    = 0;
    int          sent_count    = 0;
    int          past_count    = 0;
    int          checked_count = 0;
    bit          in_burst      = 1'b0;

    waveform_pixel_shader #(
        .ROW_BITS        (ROW_BITS),
        .LEVEL_FRAC_BITS (FRAC)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_px       (px_in),
        .o_px       (px_out)
    );

    // 20 ns clock.
    always #10 i_clk = ~i_clk;

    // Row counts below two behave as two.
    function automatic longint effective_rows();
        return (strip_rows < 2) ? longint'(2) : longint'(strip_rows);
    endfunction

    // Level of a row in Q.FRAC, +1 at the top, extrapolated past the last row.
    function automatic longint row_level(input logic [ROW_BITS-1:0] row);
        longint den;
        den = effective_rows() - 1;
        return (longint'(1) << FRAC) - (((longint'(row) * 2) << FRAC) + den / 2) / den;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint v);
        if (v < -32768) return 16'sh8000;
        if (v > 32767) return 16'sh7FFF;
        return v[SAMPLE_W-1:0];
    endfunction

    // Shaded and played colours for one pixel at the current settings.
    function automatic t_pixel_pair shade_pixel(input logic signed [SAMPLE_W-1:0] lo,
                                                input logic signed [SAMPLE_W-1:0] hi,
                                                input logic [ROW_BITS-1:0] row);
        longint      one, level, dist_lo, dist_hi, weight, b, g, h, t;
        int          ch;
        t_pixel_pair res;
        one     = longint'(1) << FRAC;
        level   = row_level(row);
        dist_lo = level - longint'(lo);
        dist_hi = level - longint'(hi);
        if (dist_lo < 0) dist_lo = -dist_lo;
        if (dist_hi < 0) dist_hi = -dist_hi;
        // Outside the span, or on an edge, the weight is zero and the background shows.
        if (level < longint'(lo) || level > longint'(hi)) begin
            weight = 0;
        end else begin
            weight = 7 * ((dist_lo < dist_hi) ? dist_lo : dist_hi);
        end
        for (ch = 0; ch < 3; ch++) begin
            b = longint'(bg_colour[8*ch +: 8]);
            g = longint'(fg_colour[8*ch +: 8]);
            h = longint'(hl_colour[8*ch +: 8]);
            t = b * one + weight * (g - b);
            if (t < 0) t = 0;
            if (t > 255 * one) t = 255 * one;
            res.plain[8*ch +: 8]  = 8'((t + one / 2) >> FRAC);
            res.played[8*ch +: 8] = 8'((h * one + 3 * t + 2 * one) >> (FRAC + 2));
        end
        return res;
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Holds the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_BACKGROUND: bg_colour  = data;
            CFG_FOREGROUND: fg_colour  = data;
            CFG_HIGHLIGHT:  hl_colour  = data;
            CFG_ROW_COUNT:  strip_rows = data[ROW_BITS:0];
            default: ;
        endcase
    endtask

    // Offer one pixel, wait for its transfer, record what should come back.
    task automatic send_pixel(input logic signed [SAMPLE_W-1:0] lo,
                              input logic signed [SAMPLE_W-1:0] hi,
                              input logic [ROW_BITS-1:0] row,
                              input logic fixed,
                              input t_pixel_pair fixed_pair);
        int gap, r;
        px_in.valid       <= 1'b1;
        px_in.sample_low  <= lo;
        px_in.sample_high <= hi;
        px_in.row         <= row;
        do @(posedge i_clk); while (px_in.ready !== 1'b1);
        pending_pixels.push_back(fixed ? fixed_pair : shade_pixel(lo, hi, row));
        sent_count++;
        if (longint'(row) >= effective_rows()) past_count++;
        // Mostly short gaps, a few long ones, and runs with none at all.
        if ($urandom_range(0, 149) == 0) in_burst = !in_burst;
        r = $urandom_range(0, 99);
        if (in_burst || r < 55) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 12);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            px_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Wait until every expected pixel has come back, then let the pipeline settle.
    task automatic drain_pipeline();
        px_in.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
    endtask

    // Output back-pressure: random stalls of mixed length, with stall-free runs.
    always @(posedge i_clk) begin
        int r;
        int stall_left;
        bit out_burst;
        if (!i_rst_n) begin
            px_out.ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 299) == 0) out_burst = !out_burst;
            if (out_burst) begin
                px_out.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                px_out.ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    px_out.ready <= 1'b1;
                end else begin
                    px_out.ready <= 1'b0;
                    if (r < 90) stall_left = $urandom_range(0, 3);
                    else if (r < 98) stall_left = $urandom_range(4, 12);
                    else stall_left = $urandom_range(20, 60);
                end
            end
        end
    end

    // Compare every output transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel_pair want;
        if (i_rst_n && px_out.valid && px_out.ready) begin
            checked_count++;
            if (pending_pixels.size() == 0) begin
                log_failure($sformatf("unexpected pixel pair %06h / %06h",
                                      px_out.plain_pixel, px_out.played_pixel));
            end else begin
                want = pending_pixels.pop_front();
                if (px_out.plain_pixel !== want.plain)
                    log_failure($sformatf("plain_pixel expected %06h, got %06h",
                                          want.plain, px_out.plain_pixel));
                if (px_out.played_pixel !== want.played)
                    log_failure($sformatf("played_pixel expected %06h, got %06h",
                                          want.played, px_out.played_pixel));
            end
        end
    end

    // Reset, directed table, then random pixels under a sequence of settings.
    initial begin
        int                         i, k, pick;
        longint                     base, level;
        logic signed [SAMPLE_W-1:0] lo, hi, tmp;
        logic [ROW_BITS-1:0]        row;
        logic [RGB_W-1:0]           shared;
        int                         rows_val;

        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_BACKGROUND;
        cfg_data          = '0;
        px_in.valid       = 1'b0;
        px_in.sample_low  = '0;
        px_in.sample_high = '0;
        px_in.row         = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows at the reset settings.
        for (i = 0; i < NUM_DIRECTED; i++) begin
            send_pixel(DIRECTED[i].lo, DIRECTED[i].hi, DIRECTED[i].row,
                       DIRECTED[i].fixed, DIRECTED[i].want);
        end
        drain_pipeline();

        for (k = 0; k < NUM_SETTINGS; k++) begin
            // Extremes first, then random colours with unusual row counts.
            case (k)
                0: begin
                    write_reg(CFG_BACKGROUND, 24'h000000);
                    write_reg(CFG_FOREGROUND, 24'hFFFFFF);
                    write_reg(CFG_HIGHLIGHT,  24'h000000);
                    write_reg(CFG_ROW_COUNT,  CFG_DATA_W'(2));
                end
                1: begin
                    write_reg(CFG_BACKGROUND, 24'hFFFFFF);
                    write_reg(CFG_FOREGROUND, 24'h000000);
                    write_reg(CFG_HIGHLIGHT,  24'hFFFFFF);
                    write_reg(CFG_ROW_COUNT,  CFG_DATA_W'(4096));
                end
                7: begin
                    shared = RGB_W'($urandom_range(0, 24'hFFFFFF));
                    write_reg(CFG_BACKGROUND, shared);
                    write_reg(CFG_FOREGROUND, shared);
                    write_reg(CFG_HIGHLIGHT,  CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
                    write_reg(CFG_ROW_COUNT,  CFG_DATA_W'(255));
                end
                default: begin
                    case (k)
                        2: rows_val = 1;
                        3: rows_val = 0;
                        4: rows_val = 64;
                        5: rows_val = 3;
                        default: rows_val = $urandom_range(2, 4096);
                    endcase
                    write_reg(CFG_BACKGROUND, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
                    write_reg(CFG_FOREGROUND, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
                    write_reg(CFG_HIGHLIGHT,  CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
                    write_reg(CFG_ROW_COUNT,  CFG_DATA_W'(rows_val));
                end
            endcase
            cfg_we <= 1'b0;

            for (i = 0; i < ITEMS_PER_SET; i++) begin
                // Mostly rows inside the strip, some past its end.
                if ($urandom_range(0, 9) == 0) row = ROW_BITS'($urandom_range(0, 4095));
                else row = ROW_BITS'($urandom_range(0, int'(effective_rows()) - 1));
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1, 2, 3, 4: begin
                        // Ordinary span somewhere in the range.
                        base = longint'($urandom_range(0, 65535)) - 32768;
                        lo   = clamp_sample(base);
                        hi   = clamp_sample(base + longint'($urandom_range(0, 24000)));
                    end
                    5, 6: begin
                        // Narrow span hugging the row level, giving small blend weights.
                        level = row_level(row);
                        lo    = clamp_sample(level - longint'($urandom_range(0, 60)));
                        hi    = clamp_sample(level + longint'($urandom_range(0, 60)));
                    end
                    7: begin
                        // Reversed span.
                        lo = SAMPLE_W'($urandom);
                        hi = SAMPLE_W'($urandom);
                        if (lo < hi) begin
                            tmp = lo;
                            lo  = hi;
                            hi  = tmp;
                        end
                    end
                    8: begin
                        lo = SAMPLE_W'($urandom);
                        hi = SAMPLE_W'($urandom);
                    end
                    default: begin
                        lo = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                        hi = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                    end
                endcase
                send_pixel(lo, hi, row, 1'b0, NO_PAIR);
            end
            drain_pipeline();
        end

        $display("Sent %0d pixels (%0d beyond the last row) over %0d register settings.",
                 sent_count, past_count, NUM_SETTINGS + 1);
        $display("Checked %0d shaded pixel pairs, %0d mismatches.", checked_count, fail_count);
        if (fail_count == 0) begin
            $display("waveform_pixel_shader verification clean");
        end else begin
            $display("waveform_pixel_shader verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legitimate run.
    initial begin
        #20_000_000;
        $display("Timed out with %0d pixels still expected.", pending_pixels.size());
        $display("waveform_pixel_shader verification failed");
        $finish;
    end

endmodule

// File: filelist.f
src/wps_pkg.sv
src/wps_in_if.sv
src/wps_out_if.sv
src/wps_divider.sv
src/wps_shade.sv
src/waveform_pixel_shader.sv
tb/sv/tb_top.sv
